// ===== hw/rtl/ugqe_pkg.sv =====
// ----------------------------------------------------------------------------
// ugqe_pkg
// Shared types and codes of the undirected graph query engine.
// ----------------------------------------------------------------------------
package ugqe_pkg;

    localparam int FUNC_W   = 3;
    localparam int VERTEX_W = 4;
    localparam int EDGE_W   = 7;
    localparam int VCOUNT_W = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REACH  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CONN   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ACYC   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_WALK   = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic                walk_start;
    } ugqe_in_t;

    typedef struct packed {
        logic              answer;
        logic [EDGE_W-1:0] edge_total_out;
    } ugqe_out_t;

endpackage

// ===== hw/rtl/undirected_graph_query_engine_top.sv =====
// ----------------------------------------------------------------------------
// undirected_graph_query_engine_top
// Insert reads row a and, for a new edge, writes rows a and b; edge test and walk step
// read one row. Reach/connected sweep rows until the reach set stops growing (1..n
// sweeps); reach does none if a vertex is out of range or a equals b. Acyclic adds a degree sweep.
// Throughput: one item at a time; s_ready is high only when idle.
// Reset: synchronous, active low; rows read as zero until written (per-row
// valid flops), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module undirected_graph_query_engine_top #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ugqe_pkg::ugqe_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ugqe_pkg::ugqe_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ugqe_pkg::VCOUNT_W-1:0]     cfg_data
);
    import ugqe_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DEG_W = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] ONE_V = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_INS_A = 4'd2;
    localparam logic [3:0] ST_INS_B = 4'd3;
    localparam logic [3:0] ST_EDGE  = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_CLOSE = 4'd6;
    localparam logic [3:0] ST_DEG   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]              state_reg, state_next;
    ugqe_in_t                item_reg, item_next;
    logic [VCOUNT_W-1:0]     vcount_reg, vcount_next;
    logic [EDGE_W-1:0]       edge_total_reg, edge_total_next;
    logic [MAX_VERTICES-1:0] walk_seen_reg, walk_seen_next;
    logic [VERTEX_W-1:0]     walk_prev_reg, walk_prev_next;
    logic                    walk_ok_reg, walk_ok_next;
    logic [MAX_VERTICES-1:0] reach_reg, reach_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    pipe_vld_reg, pipe_vld_next;
    logic [AW-1:0]           pipe_idx_reg, pipe_idx_next;
    logic                    chg_reg, chg_next;
    logic [DEG_W-1:0]        deg_reg, deg_next;
    logic [CNT_W-1:0]        vcnt_reg, vcnt_next;
    logic                    ans_reg, ans_next;
    logic                    m_valid_reg, m_valid_next;
    ugqe_out_t               m_data_reg, m_data_next;
    logic [MAX_VERTICES-1:0] row_vld_reg;
    logic                    rd_vld_reg;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [MAX_VERTICES-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic [MAX_VERTICES-1:0] ram_rd_data;

    logic [CNT_W-1:0]        n_eff;
    logic [MAX_VERTICES-1:0] mask;
    logic [MAX_VERTICES-1:0] row_eff;
    logic [MAX_VERTICES-1:0] a_onehot, b_onehot, prev_onehot;
    logic [AW-1:0]           a_addr, b_addr;
    logic                    a_ok, b_ok;
    logic                    sweep_issue, sweep_proc, sweep_end;
    logic [DEG_W-1:0]        half_plus;

    logic [MAX_VERTICES-1:0] alu_reach_new;
    logic                    alu_grew;
    logic [CNT_W-1:0]        alu_deg;

    ugqe_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ugqe_row_alu #(
        .WIDTH (MAX_VERTICES)
    ) u_row_alu (
        .row       (row_eff),
        .reach     (reach_reg),
        .mask      (mask),
        .reach_new (alu_reach_new),
        .grew      (alu_grew),
        .deg_cnt   (alu_deg)
    );

    // effective vertex count: 0 acts as 1, clipped to MAX_VERTICES
    always_comb begin
        if (vcount_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(vcount_reg) > MAX_VERTICES) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(vcount_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            mask[i] = (i < int'(n_eff));
        end
    end

    assign row_eff     = rd_vld_reg ? ram_rd_data : '0;
    assign a_onehot    = ONE_V << item_reg.vertex_a;
    assign b_onehot    = ONE_V << item_reg.vertex_b;
    assign prev_onehot = ONE_V << walk_prev_reg;
    assign a_addr      = AW'(item_reg.vertex_a);
    assign b_addr      = AW'(item_reg.vertex_b);
    assign a_ok        = int'(item_reg.vertex_a) < int'(n_eff);
    assign b_ok        = int'(item_reg.vertex_b) < int'(n_eff);

    assign sweep_issue = idx_reg < n_eff;
    assign sweep_proc  = pipe_vld_reg && |(reach_reg & (ONE_V << pipe_idx_reg));
    assign sweep_end   = !sweep_issue && !pipe_vld_reg;
    assign half_plus   = (deg_reg >> 1) + DEG_W'(1);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        vcount_next     = cfg_valid ? cfg_data : vcount_reg;
        edge_total_next = edge_total_reg;
        walk_seen_next  = walk_seen_reg;
        walk_prev_next  = walk_prev_reg;
        walk_ok_next    = walk_ok_reg;
        reach_next      = reach_reg;
        idx_next        = idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        chg_next        = chg_reg;
        deg_next        = deg_reg;
        vcnt_next       = vcnt_reg;
        ans_next        = ans_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = a_addr;
        ram_wr_data     = row_eff;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = a_addr;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                ans_next   = 1'b0;
                state_next = ST_DONE;
                idx_next   = '0;
                chg_next   = 1'b0;
                unique case (item_reg.func)
                    FUNC_INSERT: begin
                        if (a_ok && b_ok && item_reg.vertex_a != item_reg.vertex_b) begin
                            ram_rd_en  = 1'b1;
                            state_next = ST_INS_A;
                        end
                    end
                    FUNC_EDGE: begin
                        if (a_ok && b_ok) begin
                            ram_rd_en  = 1'b1;
                            state_next = ST_EDGE;
                        end
                    end
                    FUNC_REACH: begin
                        if (a_ok && b_ok) begin
                            if (item_reg.vertex_a == item_reg.vertex_b) begin
                                ans_next = 1'b1;
                            end else begin
                                reach_next = a_onehot;
                                state_next = ST_CLOSE;
                            end
                        end
                    end
                    FUNC_CONN, FUNC_ACYC: begin
                        reach_next = ONE_V;
                        state_next = ST_CLOSE;
                    end
                    FUNC_WALK: begin
                        if (a_ok) begin
                            if (item_reg.walk_start) begin
                                walk_seen_next = a_onehot;
                                walk_prev_next = item_reg.vertex_a;
                                walk_ok_next   = 1'b1;
                                ans_next       = 1'b1;
                            end else if (walk_ok_reg &&
                                         int'(walk_prev_reg) < int'(n_eff)) begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_WALK;
                            end else begin
                                walk_ok_next = 1'b0;
                            end
                        end
                    end
                    default: begin
                        ans_next = 1'b0;
                    end
                endcase
            end
            ST_INS_A: begin
                if (|(row_eff & b_onehot)) begin
                    state_next = ST_DONE;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = a_addr;
                    ram_wr_data = row_eff | b_onehot;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = b_addr;
                    state_next  = ST_INS_B;
                end
            end
            ST_INS_B: begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = b_addr;
                ram_wr_data     = row_eff | a_onehot;
                edge_total_next = edge_total_reg + EDGE_W'(1);
                ans_next        = 1'b1;
                state_next      = ST_DONE;
            end
            ST_EDGE: begin
                ans_next   = |(row_eff & b_onehot);
                state_next = ST_DONE;
            end
            ST_WALK: begin
                if (|(row_eff & prev_onehot) && !(|(walk_seen_reg & a_onehot))) begin
                    walk_seen_next = walk_seen_reg | a_onehot;
                    walk_prev_next = item_reg.vertex_a;
                    ans_next       = 1'b1;
                end else begin
                    walk_ok_next = 1'b0;
                    ans_next     = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_CLOSE, ST_DEG: begin
                // one row read issued per cycle, row data used the cycle after
                if (sweep_issue) begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg[AW-1:0];
                end
                if (state_reg == ST_CLOSE) begin
                    if (sweep_proc) begin
                        reach_next = alu_reach_new;
                        if (alu_grew) begin
                            chg_next = 1'b1;
                        end
                    end
                    if (sweep_end) begin
                        if (chg_reg) begin
                            idx_next = '0;
                            chg_next = 1'b0;
                        end else if (item_reg.func == FUNC_REACH) begin
                            ans_next   = |(reach_reg & b_onehot);
                            state_next = ST_DONE;
                        end else if (item_reg.func == FUNC_CONN) begin
                            ans_next   = (reach_reg == mask);
                            state_next = ST_DONE;
                        end else begin
                            idx_next   = '0;
                            deg_next   = '0;
                            vcnt_next  = '0;
                            state_next = ST_DEG;
                        end
                    end
                end else begin
                    if (sweep_proc) begin
                        deg_next  = deg_reg + DEG_W'(alu_deg);
                        vcnt_next = vcnt_reg + CNT_W'(1);
                    end
                    if (sweep_end) begin
                        // tree test: edges == vertices - 1, degree sum counts edges twice
                        ans_next   = (half_plus == DEG_W'(vcnt_reg));
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.answer         = ans_reg;
                    m_data_next.edge_total_out = edge_total_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= VCOUNT_RESET;
            edge_total_reg <= '0;
            walk_seen_reg  <= '0;
            walk_prev_reg  <= '0;
            walk_ok_reg    <= 1'b1;
            pipe_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            row_vld_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            edge_total_reg <= edge_total_next;
            walk_seen_reg  <= walk_seen_next;
            walk_prev_reg  <= walk_prev_next;
            walk_ok_reg    <= walk_ok_next;
            pipe_vld_reg   <= pipe_vld_next;
            m_valid_reg    <= m_valid_next;
            if (ram_wr_en) begin
                row_vld_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        reach_reg    <= reach_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        chg_reg      <= chg_next;
        deg_reg      <= deg_next;
        vcnt_reg     <= vcnt_next;
        ans_reg      <= ans_next;
        m_data_reg   <= m_data_next;
        if (ram_rd_en) begin
            rd_vld_reg <= row_vld_reg[ram_rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ugqe_ram.sv =====
// ----------------------------------------------------------------------------
// ugqe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ugqe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ugqe_row_alu.sv =====
// ----------------------------------------------------------------------------
// ugqe_row_alu
// Shared row unit: merges one adjacency row into the reach set and counts
// the row's neighbors that lie inside the reach set.
// ----------------------------------------------------------------------------
module ugqe_row_alu #(
    parameter int WIDTH = 16,
    localparam int CW = $clog2(WIDTH + 1)
) (
    input  logic [WIDTH-1:0] row,
    input  logic [WIDTH-1:0] reach,
    input  logic [WIDTH-1:0] mask,
    output logic [WIDTH-1:0] reach_new,
    output logic             grew,
    output logic [CW-1:0]    deg_cnt
);

    logic [WIDTH-1:0] in_reach;

    assign reach_new = reach | (row & mask);
    assign grew      = (reach_new != reach);
    assign in_reach  = row & reach & mask;

    always_comb begin
        deg_cnt = '0;
        for (int i = 0; i < WIDTH; i++) begin
            deg_cnt = deg_cnt + CW'(in_reach[i]);
        end
    end

endmodule

// ===== hw/rtl/ugqe_checker.sv =====
// ----------------------------------------------------------------------------
// ugqe_checker
// Port-level checks of the graph query engine, bound to the top level.
// ----------------------------------------------------------------------------
module ugqe_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ugqe_pkg::ugqe_out_t m_data
);
    import ugqe_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // a fresh result only comes out of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without an item in flight");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind undirected_graph_query_engine_top ugqe_checker u_ugqe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/tb_undirected_graph_query_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_undirected_graph_query_engine_top
// Self-checking bench for the graph query engine: a queue-fed driver, a
// result monitor and an in-bench graph predictor. Directed beats hit the
// corner cases, then randomized phases run at different vertex counts with
// forest building, sparse inserts, queries and path walks along real edges.
// ----------------------------------------------------------------------------
module tb_undirected_graph_query_engine_top;
    import ugqe_pkg::*;

    localparam int VERTEX_SLOTS = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = 400;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_WALK + 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

    typedef enum {PACE_SINK_HEAVY, PACE_SOURCE_HEAVY, PACE_FREE} pace_t;

    typedef struct packed {
        logic [VERTEX_SLOTS-1:0][VERTEX_SLOTS-1:0] adj;
        logic [EDGE_W-1:0]                         edges;
        logic [VERTEX_SLOTS-1:0]                   seen;
        logic [VERTEX_W-1:0]                       prev;
        logic                                      ok;
        logic [VCOUNT_W-1:0]                       vcount;
    } graph_state_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    ugqe_in_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    ugqe_out_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_data  = '0;

    ugqe_in_t     pending_items[$];
    ugqe_out_t    answer_due[$];
    graph_state_t dut_graph;
    graph_state_t plan_graph;
    ugqe_out_t    due_beat;
    ugqe_out_t    check_beat;
    logic         source_busy;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           forest_next    = 2;

    undirected_graph_query_engine_top #(
        .MAX_VERTICES(VERTEX_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Graph predictor
    // ------------------------------------------------------------------
    function automatic int live_vertices(logic [VCOUNT_W-1:0] vc);
        if (vc == '0) return 1;
        if (int'(vc) > VERTEX_SLOTS) return VERTEX_SLOTS;
        return int'(vc);
    endfunction

    function automatic logic [VERTEX_SLOTS-1:0] live_mask(int n);
        if (n >= VERTEX_SLOTS) return '1;
        return (VERTEX_SLOTS'(1) << n) - 1'b1;
    endfunction

    function automatic logic [VERTEX_SLOTS-1:0] reach_set(graph_state_t g, int src, int n);
        logic [VERTEX_SLOTS-1:0] mask;
        logic [VERTEX_SLOTS-1:0] r;
        logic [VERTEX_SLOTS-1:0] last;
        mask   = live_mask(n);
        r      = '0;
        r[src] = 1'b1;
        do begin
            last = r;
            for (int v = 0; v < n; v++) begin
                if (r[v]) r |= g.adj[v] & mask;
            end
        end while (r != last);
        return r;
    endfunction

    function automatic ugqe_out_t graph_step(inout graph_state_t g, input ugqe_in_t it);
        int                      n;
        int                      a;
        int                      b;
        int                      deg;
        logic                    ans;
        logic [VERTEX_SLOTS-1:0] r;
        logic [VERTEX_SLOTS-1:0] mask;
        ugqe_out_t               res;
        n    = live_vertices(g.vcount);
        a    = int'(it.vertex_a);
        b    = int'(it.vertex_b);
        mask = live_mask(n);
        ans  = 1'b0;
        case (it.func)
            FUNC_INSERT: begin
                if (a < n && b < n && a != b && !g.adj[a][b]) begin
                    g.adj[a][b] = 1'b1;
                    g.adj[b][a] = 1'b1;
                    g.edges     = g.edges + 1'b1;
                    ans         = 1'b1;
                end
            end
            FUNC_EDGE: begin
                if (a < n && b < n) ans = g.adj[a][b];
            end
            FUNC_REACH: begin
                if (a < n && b < n) begin
                    r   = reach_set(g, a, n);
                    ans = (a == b) || r[b];
                end
            end
            FUNC_CONN: begin
                ans = ($countones(reach_set(g, 0, n)) == n);
            end
            FUNC_ACYC: begin
                r   = reach_set(g, 0, n);
                deg = 0;
                for (int v = 0; v < n; v++) begin
                    if (r[v]) deg += $countones(g.adj[v] & r & mask);
                end
                // a tree has one vertex more than it has edges
                ans = (deg / 2 + 1 == $countones(r));
            end
            FUNC_WALK: begin
                if (a < n) begin
                    if (it.walk_start) begin
                        g.seen    = '0;
                        g.seen[a] = 1'b1;
                        g.prev    = it.vertex_a;
                        g.ok      = 1'b1;
                    end else if (g.ok && int'(g.prev) < n && g.adj[a][g.prev] && !g.seen[a]) begin
                        g.seen[a] = 1'b1;
                        g.prev    = it.vertex_a;
                    end else begin
                        g.ok = 1'b0;
                    end
                    ans = g.ok;
                end
            end
            default: ;
        endcase
        res.answer         = ans;
        res.edge_total_out = g.edges;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one beat in flight, held until accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            source_busy = s_valid;
            if (s_valid && s_ready) begin
                due_beat   = graph_step(dut_graph, s_data);
                answer_due = {answer_due, due_beat};
                source_busy = 1'b0;
            end
            if (!source_busy) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (answer_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result beat answer %0d edges %0d",
                                 $realtime, m_data.answer, m_data.edge_total_out);
                end else begin
                    check_beat = answer_due.pop_front();
                    if (m_data.answer !== check_beat.answer ||
                        m_data.edge_total_out !== check_beat.edge_total_out) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch answer exp %0d got %0d, edges exp %0d got %0d",
                                     $realtime, check_beat.answer, m_data.answer,
                                     check_beat.edge_total_out, m_data.edge_total_out);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input ugqe_in_t it);
        pending_items = {pending_items, it};
        void'(graph_step(plan_graph, it));
    endtask

    task automatic push_item(input logic [FUNC_W-1:0] f, input int a, input int b,
                             input logic start);
        ugqe_in_t it;
        it.func       = f;
        it.vertex_a   = VERTEX_W'(a);
        it.vertex_b   = VERTEX_W'(b);
        it.walk_start = start;
        queue_item(it);
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SINK_HEAVY: begin
                send_idle_pct = 35;
                stall_pct     = 63;
            end
            PACE_SOURCE_HEAVY: begin
                send_idle_pct = 63;
                stall_pct     = 35;
            end
            default: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
        endcase
    endtask

    // sampled mid-cycle so a beat popped at this edge already shows on s_valid
    task automatic drain();
        while (pending_items.size() != 0 || s_valid || answer_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_vertex_count(input logic [VCOUNT_W-1:0] vc);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= vc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dut_graph.vcount  = vc;
        plan_graph.vcount = vc;
    endtask

    // mostly in range, now and then any vertex
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        int n;
        n = live_vertices(plan_graph.vcount);
        if ($urandom_range(0, 9) == 0) return VERTEX_W'($urandom_range(0, VERTEX_SLOTS - 1));
        return VERTEX_W'($urandom_range(0, n - 1));
    endfunction

    // walk along actual edges of the planned graph, with the odd wrong step
    task automatic queue_walk(output int pushed);
        ugqe_in_t                it;
        logic [VERTEX_SLOTS-1:0] cand;
        int                      n;
        int                      k;
        n             = live_vertices(plan_graph.vcount);
        it.func       = FUNC_WALK;
        it.vertex_a   = pick_vertex();
        it.vertex_b   = pick_vertex();
        it.walk_start = ($urandom_range(0, 9) != 0);
        queue_item(it);
        pushed = 1;
        repeat ($urandom_range(1, 6)) begin
            cand          = plan_graph.adj[plan_graph.prev] & ~plan_graph.seen & live_mask(n);
            it.walk_start = 1'b0;
            it.vertex_a   = pick_vertex();
            it.vertex_b   = pick_vertex();
            if (cand != '0 && $urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, $countones(cand) - 1);
                for (int v = 0; v < VERTEX_SLOTS; v++) begin
                    if (cand[v]) begin
                        if (k == 0) it.vertex_a = VERTEX_W'(v);
                        k--;
                    end
                end
            end
            queue_item(it);
            pushed++;
        end
    endtask

    task automatic run_phase(input logic [VCOUNT_W-1:0] vc, input int items,
                             input int insert_pct, input pace_t pace);
        ugqe_in_t it;
        int       made;
        int       roll;
        int       pushed;
        set_pace(pace);
        write_vertex_count(vc);
        made = 0;
        while (made < items) begin
            roll          = $urandom_range(0, 99);
            it.vertex_a   = pick_vertex();
            it.vertex_b   = pick_vertex();
            it.walk_start = 1'($urandom_range(0, 1));
            pushed        = 1;
            if (roll < insert_pct) begin
                it.func = FUNC_INSERT;
                // grow a forest first: each child hangs off a lower vertex, some stay apart
                if (forest_next < VERTEX_SLOTS - 1) begin
                    if ($urandom_range(0, 3) != 0) begin
                        it.vertex_a = VERTEX_W'(forest_next);
                        it.vertex_b = VERTEX_W'($urandom_range(0, forest_next - 1));
                    end
                    forest_next++;
                end
                queue_item(it);
            end else if (roll < insert_pct + 14) begin
                it.func = FUNC_EDGE;
                queue_item(it);
            end else if (roll < insert_pct + 32) begin
                it.func = FUNC_REACH;
                queue_item(it);
            end else if (roll < insert_pct + 38) begin
                it.func = FUNC_CONN;
                queue_item(it);
            end else if (roll < insert_pct + 44) begin
                it.func = FUNC_ACYC;
                queue_item(it);
            end else if (roll < insert_pct + 48) begin
                it.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                queue_item(it);
            end else begin
                queue_walk(pushed);
            end
            made += pushed;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        dut_graph        = '0;
        dut_graph.ok     = 1'b1;
        dut_graph.vcount = VCOUNT_RESET;
        plan_graph       = dut_graph;
        set_pace(PACE_SINK_HEAVY);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // walk with no start beat continues from vertex 0 with nothing seen
        push_item(FUNC_INSERT, 0, 1, 1'b0);
        push_item(FUNC_WALK, 1, 0, 1'b0);
        push_item(FUNC_WALK, 0, 0, 1'b0);
        push_item(FUNC_WALK, 1, 0, 1'b0);
        push_item(FUNC_INSERT, 1, 0, 1'b1);
        push_item(FUNC_INSERT, 3, 3, 1'b0);
        push_item(FUNC_INSERT, 15, 1, 1'b0);
        push_item(FUNC_EDGE, 1, 15, 1'b1);
        push_item(FUNC_ACYC, 0, 0, 1'b0);
        push_item(FUNC_INSERT, 0, 15, 1'b0);
        push_item(FUNC_ACYC, 15, 15, 1'b1);
        push_item(FUNC_REACH, 7, 7, 1'b0);
        push_item(FUNC_REACH, 0, 15, 1'b0);
        push_item(FUNC_REACH, 0, 8, 1'b0);
        push_item(FUNC_CONN, 0, 0, 1'b0);
        push_item(FUNC_WALK, 15, 0, 1'b1);
        push_item(FUNC_WALK, 0, 0, 1'b0);
        push_item(FUNC_WALK, 1, 0, 1'b0);
        push_item(FUNC_WALK, 15, 0, 1'b0);
        push_item(FUNC_SPARE_LO, 15, 15, 1'b1);
        drain();

        // vertex 15 hidden: its edges stay stored but drop out of every query
        write_vertex_count(5'd3);
        push_item(FUNC_INSERT, 0, 3, 1'b0);
        push_item(FUNC_EDGE, 1, 15, 1'b0);
        push_item(FUNC_REACH, 1, 15, 1'b0);
        push_item(FUNC_CONN, 0, 0, 1'b0);
        push_item(FUNC_ACYC, 0, 0, 1'b0);
        push_item(FUNC_WALK, 15, 0, 1'b1);
        push_item(FUNC_INSERT, 2, 1, 1'b0);
        push_item(FUNC_CONN, 0, 0, 1'b1);
        drain();

        run_phase(5'd16, 140, 15, PACE_SINK_HEAVY);
        run_phase(5'd0, 60, 8, PACE_SINK_HEAVY);
        run_phase(5'd31, 140, 6, PACE_SINK_HEAVY);
        run_phase(5'd5, 140, 8, PACE_SOURCE_HEAVY);
        run_phase(5'd1, 60, 5, PACE_SOURCE_HEAVY);
        run_phase(5'd12, 160, 8, PACE_SOURCE_HEAVY);
        run_phase(5'd17, 160, 8, PACE_FREE);
        run_phase(5'd9, 160, 8, PACE_FREE);
        run_phase(5'd16, 160, 10, PACE_FREE);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (answer_due.size() != 0) begin
            $display("%0d result beats never arrived", answer_due.size());
            mismatch_count += answer_due.size();
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ugqe_pkg.sv
hw/rtl/ugqe_ram.sv
hw/rtl/ugqe_row_alu.sv
hw/rtl/undirected_graph_query_engine_top.sv
hw/rtl/ugqe_checker.sv
bench/tb_undirected_graph_query_engine_top.sv
